// ===== sv/gcib_pkg.sv =====
// ============================================================================
// gcib_pkg
// Shared constants, widths and the arctangent table for the bearing pipeline.
// ============================================================================
package gcib_pkg;

    // Number of CORDIC iterations in each rotator.
    localparam int CORDIC_STAGES = 20;

    // Datapath widths.
    localparam int PH_W = 32;   // angle phase, 2^32 is a full turn
    localparam int SC_W = 34;   // sine/cosine rotator, Q30 plus headroom
    localparam int MP_W = 2 * SC_W;
    localparam int AV_W = 36;   // east/north vector entering the arctangent
    localparam int AT_W = 38;   // vectoring rotator with gain headroom
    localparam int HD_W = 17;   // heading and bearing, 1/256 degree

    // Degree-to-phase conversion: q = round(mag * 2^22 / 3515625).
    localparam logic [21:0] PH_DIV      = 22'd3515625;
    localparam logic [53:0] PH_HALF_DIV = 54'd1757812;
    // Reciprocal floor(2^54 / 3515625), split at bit 17.
    localparam logic [15:0] PH_MUL_HI   = 16'd39093;
    localparam logic [16:0] PH_MUL_LO   = 17'd97880;

    // Rotator start amplitude: 1.0 in Q30 divided by the CORDIC gain.
    localparam logic signed [SC_W-1:0] SC_AMP     = SC_W'(64'sd652032874);
    localparam logic signed [SC_W-1:0] SC_QUARTER = SC_W'(64'sd1073741824);
    localparam logic signed [SC_W-1:0] SC_HALF    = SC_W'(64'sd2147483648);

    // One full turn in output units.
    localparam logic [HD_W-1:0] FULL_TURN_OUT = 17'd92160;

    // Configuration register indexes (address bit 2).
    localparam logic REG_DEST_LAT = 1'b0;
    localparam logic REG_DEST_LON = 1'b1;

    // Pipeline latencies.
    localparam int PH_LAT   = 5;
    localparam int DL_LAT   = 1;
    localparam int SC_LAT   = CORDIC_STAGES + 2;
    localparam int MUL_LAT  = 4;
    localparam int AT_LAT   = CORDIC_STAGES + 3;
    localparam int PIPE_LAT = PH_LAT + DL_LAT + SC_LAT + MUL_LAT + AT_LAT;

    // atan(2^-i) as a phase of a 2^32 full turn.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    function automatic logic [31:0] cordic_atan(input int idx);
        logic [4:0] k;
        k = 5'(idx);
        return ATAN_TAB[k];
    endfunction

endpackage

// ===== sv/gcib_if.sv =====
// ============================================================================
// gcib_if
// Valid/ready channels for position requests and bearing results.
// ============================================================================
interface gcib_in_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] current_lat;
    logic signed [31:0] current_lon;
    logic [16:0]        compass_deg;

    modport source (output valid, current_lat, current_lon, compass_deg, input ready);
    modport sink   (input valid, current_lat, current_lon, compass_deg, output ready);
endinterface

interface gcib_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] current_heading;
    logic [16:0] target_bearing;

    modport source (output valid, current_heading, target_bearing, input ready);
    modport sink   (input valid, current_heading, target_bearing, output ready);
endinterface

// ===== sv/great_circle_initial_bearing.sv =====
// ============================================================================
// great_circle_initial_bearing
// Initial great-circle bearing from the current position to a set destination.
// ============================================================================
//
//  Channel   Direction  Handshake        Contents
//  -------   ---------  ---------        --------
//  in_req    sink       valid/ready      current_lat, current_lon, compass_deg
//  out_res   source     valid/ready      current_heading, target_bearing
//  APB       slave      psel/penable     dest_lat at 0x0, dest_lon at 0x4
//
//  A request enters every cycle while the output is not stalled; its result
//  passes through the phase conversion, two unrolled CORDIC rotators and the
//  product stages between them.
//  Reset clears the valid bits and both destination registers.
//  All stages advance together whenever the output register is empty or being
//  taken; a stalled output holds the whole pipeline in place.
//
module great_circle_initial_bearing (
    input  logic        clk,
    input  logic        rst_n,
    gcib_in_if.sink     in_req,
    gcib_out_if.source  out_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gcib_pkg::*;

    logic [30:0] dest_lat_reg;
    logic [31:0] dest_lon_reg;

    logic            vld_reg [0:PIPE_LAT-1];
    logic [HD_W-1:0] hd_reg  [0:PIPE_LAT-1];
    logic            en;

    logic [PH_W-1:0] pa, pb, plon_a, plon_b;
    logic [PH_W-1:0] pa_reg, pb_reg, pdl_reg;

    logic signed [SC_W-1:0] ca, sa, cb, sb, cdl, sdl;

    logic signed [MP_W-1:0] cbsdl_m1_reg, sacb_m1_reg, casb_m1_reg, casb_m2_reg, casb_m3_reg;
    logic signed [MP_W-1:0] tcdl_m3_reg;
    logic signed [SC_W-1:0] cdl_m1_reg, cdl_m2_reg, t_m2_reg;
    logic signed [AV_W-1:0] xv_m2_reg, xv_m3_reg, xv_m4_reg, yv_m4_reg;
    logic signed [MP_W-1:0] ydiff;

    logic [HD_W-1:0] bearing;

    // Configuration writes and read-back.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_lat_reg <= '0;
            dest_lon_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_DEST_LAT: dest_lat_reg <= pwdata[30:0];
                REG_DEST_LON: dest_lon_reg <= pwdata;
                default:      dest_lon_reg <= dest_lon_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DEST_LAT: prdata = 32'(dest_lat_reg);
            REG_DEST_LON: prdata = dest_lon_reg;
            default:      prdata = '0;
        endcase
    end

    // The pipeline advances whenever the output register can move.
    assign en           = !vld_reg[PIPE_LAT-1] || out_res.ready;
    assign in_req.ready = en;

    // Valid bits and the heading travel alongside the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_req.valid;
            for (int k = 1; k < PIPE_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hd_reg[0] <= in_req.compass_deg;
            for (int k = 1; k < PIPE_LAT; k++)
            begin
                hd_reg[k] <= hd_reg[k-1];
            end
        end
    end

    // Degrees to phase for all four coordinates.
    gcib_phase u_ph_lat_a (.clk(clk), .en(en), .angle(32'(in_req.current_lat)), .phase(pa));
    gcib_phase u_ph_lat_b (.clk(clk), .en(en), .angle(32'(signed'(dest_lat_reg))), .phase(pb));
    gcib_phase u_ph_lon_a (.clk(clk), .en(en), .angle(in_req.current_lon), .phase(plon_a));
    gcib_phase u_ph_lon_b (.clk(clk), .en(en), .angle(signed'(dest_lon_reg)), .phase(plon_b));

    // Longitude difference wraps modulo a full turn.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= pa;
            pb_reg  <= pb;
            pdl_reg <= plon_b - plon_a;
        end
    end

    gcib_sincos u_sc_a  (.clk(clk), .en(en), .phase(pa_reg),  .cos_q(ca),  .sin_q(sa));
    gcib_sincos u_sc_b  (.clk(clk), .en(en), .phase(pb_reg),  .cos_q(cb),  .sin_q(sb));
    gcib_sincos u_sc_dl (.clk(clk), .en(en), .phase(pdl_reg), .cos_q(cdl), .sin_q(sdl));

    // East and north components, one multiply level per stage.
    assign ydiff = casb_m3_reg - tcdl_m3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cbsdl_m1_reg <= MP_W'(cb) * MP_W'(sdl);
            sacb_m1_reg  <= MP_W'(sa) * MP_W'(cb);
            casb_m1_reg  <= MP_W'(ca) * MP_W'(sb);
            cdl_m1_reg   <= cdl;

            xv_m2_reg    <= AV_W'(cbsdl_m1_reg >>> 30);
            t_m2_reg     <= SC_W'(sacb_m1_reg >>> 30);
            casb_m2_reg  <= casb_m1_reg;
            cdl_m2_reg   <= cdl_m1_reg;

            tcdl_m3_reg  <= MP_W'(t_m2_reg) * MP_W'(cdl_m2_reg);
            casb_m3_reg  <= casb_m2_reg;
            xv_m3_reg    <= xv_m2_reg;

            yv_m4_reg    <= AV_W'(ydiff >>> 30);
            xv_m4_reg    <= xv_m3_reg;
        end
    end

    gcib_atan2 u_atan2 (
        .clk     (clk),
        .en      (en),
        .east    (xv_m4_reg),
        .north   (yv_m4_reg),
        .bearing (bearing)
    );

    assign out_res.valid           = vld_reg[PIPE_LAT-1];
    assign out_res.current_heading = hd_reg[PIPE_LAT-1];
    assign out_res.target_bearing  = bearing;

endmodule

// ===== sv/gcib_phase.sv =====
// ============================================================================
// gcib_phase
// Converts an angle in 1e-7 degree to a 32-bit phase with rounding.
// ============================================================================
module gcib_phase (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [31:0]           angle,
    output logic [gcib_pkg::PH_W-1:0]    phase
);
    import gcib_pkg::*;

    logic [31:0] mag_s1_reg, mag_s2_reg, mag_s3_reg, mag_s4_reg;
    logic        neg_s1_reg, neg_s2_reg, neg_s3_reg, neg_s4_reg;
    logic [47:0] hi_s2_reg;
    logic [48:0] lo_s2_reg;
    logic [31:0] q0_s3_reg, q0_s4_reg;
    logic [53:0] qd_s4_reg;
    logic [PH_W-1:0] phase_reg;

    logic [31:0] mag_next;
    logic [64:0] sum_next;
    logic [53:0] num_s4, rem_s4;
    logic [31:0] q_next;
    logic [PH_W-1:0] phase_next;

    // Magnitude of the angle; the most negative value still fits unsigned.
    always_comb
    begin
        mag_next = angle[31] ? 32'(33'sd0 - 33'(angle)) : 32'(angle);
    end

    // Reciprocal product assembled from its two partial products.
    always_comb
    begin
        sum_next = 65'({hi_s2_reg, 17'b0}) + 65'(lo_s2_reg);
    end

    // Remainder correction: the estimate is low by at most two.
    always_comb
    begin
        num_s4 = {mag_s4_reg, 22'b0} + PH_HALF_DIV;
        rem_s4 = num_s4 - qd_s4_reg;
        priority if (rem_s4 >= 54'(2 * PH_DIV))
        begin
            q_next = q0_s4_reg + 32'd2;
        end
        else if (rem_s4 >= 54'(PH_DIV))
        begin
            q_next = q0_s4_reg + 32'd1;
        end
        else
        begin
            q_next = q0_s4_reg;
        end
        phase_next = neg_s4_reg ? (32'd0 - q_next) : q_next;
    end

    // Five register stages, all advancing together.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_s1_reg <= mag_next;
            neg_s1_reg <= angle[31];

            hi_s2_reg  <= 48'(mag_s1_reg) * 48'(PH_MUL_HI);
            lo_s2_reg  <= 49'(mag_s1_reg) * 49'(PH_MUL_LO);
            mag_s2_reg <= mag_s1_reg;
            neg_s2_reg <= neg_s1_reg;

            q0_s3_reg  <= sum_next[63:32];
            mag_s3_reg <= mag_s2_reg;
            neg_s3_reg <= neg_s2_reg;

            qd_s4_reg  <= 54'(q0_s3_reg) * 54'(PH_DIV);
            q0_s4_reg  <= q0_s3_reg;
            mag_s4_reg <= mag_s3_reg;
            neg_s4_reg <= neg_s3_reg;

            phase_reg  <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ===== sv/gcib_sincos.sv =====
// ============================================================================
// gcib_sincos
// Unrolled rotation-mode CORDIC giving cosine and sine in Q30.
// ============================================================================
module gcib_sincos (
    input  logic                              clk,
    input  logic                              en,
    input  logic [gcib_pkg::PH_W-1:0]         phase,
    output logic signed [gcib_pkg::SC_W-1:0]  cos_q,
    output logic signed [gcib_pkg::SC_W-1:0]  sin_q
);
    import gcib_pkg::*;

    logic signed [SC_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [SC_W-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [SC_W-1:0] z_reg [0:CORDIC_STAGES];
    logic                   neg_reg [0:CORDIC_STAGES];
    logic signed [SC_W-1:0] cos_reg, sin_reg;

    logic signed [SC_W-1:0] z_signed, z_fold;
    logic                   neg_fold;

    // Fold the angle into [-90, 90] degrees with a half-turn and a sign flip.
    always_comb
    begin
        z_signed = SC_W'(signed'(phase));
        z_fold   = z_signed;
        neg_fold = 1'b0;
        priority if (z_signed > SC_QUARTER)
        begin
            z_fold   = z_signed - SC_HALF;
            neg_fold = 1'b1;
        end
        else if (z_signed < -SC_QUARTER)
        begin
            z_fold   = z_signed + SC_HALF;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_signed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= SC_AMP;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_fold;
            neg_reg[0] <= neg_fold;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_iter
        logic signed [SC_W-1:0] dx, dy, ang;

        always_comb
        begin
            dx  = y_reg[i] >>> i;
            dy  = x_reg[i] >>> i;
            ang = SC_W'(cordic_atan(i));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ang;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Undo the fold.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
            sin_reg <= neg_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ===== sv/gcib_atan2.sv =====
// ============================================================================
// gcib_atan2
// Unrolled vectoring CORDIC and scaling of the phase to 1/256 degree.
// ============================================================================
module gcib_atan2 (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [gcib_pkg::AV_W-1:0]  east,
    input  logic signed [gcib_pkg::AV_W-1:0]  north,
    output logic [gcib_pkg::HD_W-1:0]         bearing
);
    import gcib_pkg::*;

    logic signed [AT_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [AT_W-1:0] y_reg [0:CORDIC_STAGES];
    logic [PH_W-1:0]        z_reg [0:CORDIC_STAGES];
    logic                   zero_reg [0:CORDIC_STAGES];
    logic [48:0]            prod_reg;
    logic                   zero_p_reg;
    logic [HD_W-1:0]        bearing_reg;

    logic signed [AT_W-1:0] x_init, y_init;
    logic [PH_W-1:0]        z_init;
    logic [48:0]            round_sum;
    logic [HD_W-1:0]        bearing_next;

    // Pre-rotate by a half-turn when the north part is negative.
    always_comb
    begin
        if (north < 0)
        begin
            x_init = -AT_W'(north);
            y_init = -AT_W'(east);
            z_init = 32'h8000_0000;
        end
        else
        begin
            x_init = AT_W'(north);
            y_init = AT_W'(east);
            z_init = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_init;
            y_reg[0]    <= y_init;
            z_reg[0]    <= z_init;
            zero_reg[0] <= (north == 0) && (east == 0);
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_iter
        logic signed [AT_W-1:0] dx, dy;
        logic [PH_W-1:0]        ang;

        always_comb
        begin
            dx  = y_reg[i] >>> i;
            dy  = x_reg[i] >>> i;
            ang = cordic_atan(i);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ang;
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Rounding to output units; a full turn wraps to zero, as does a zero vector.
    always_comb
    begin
        round_sum = prod_reg + 49'h0_8000_0000;
        if (zero_p_reg || (round_sum[48:32] >= FULL_TURN_OUT))
        begin
            bearing_next = '0;
        end
        else
        begin
            bearing_next = round_sum[48:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= 49'(z_reg[CORDIC_STAGES]) * 49'(FULL_TURN_OUT);
            zero_p_reg  <= zero_reg[CORDIC_STAGES];
            bearing_reg <= bearing_next;
        end
    end

    assign bearing = bearing_reg;

endmodule

// ===== sv/gcib_checker.sv =====
// ============================================================================
// gcib_checker
// Port-level checks on the bearing pipeline, bound to the top level.
// ============================================================================
module gcib_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] out_heading,
    input logic [16:0] out_bearing
);
    import gcib_pkg::*;

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A waiting result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_bearing) && $stable(out_heading))
        else $error("result payload changed while stalled");

    // The bearing is always inside one turn.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_bearing < FULL_TURN_OUT)
        else $error("bearing out of range");

    // An empty or draining output register never blocks new requests.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("request refused with room in the pipeline");

endmodule

bind great_circle_initial_bearing gcib_checker u_gcib_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_req.ready),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .out_heading (out_res.current_heading),
    .out_bearing (out_res.target_bearing)
);
